FILE: hdl/zewd_pkg.sv
`timescale 1ns / 1ps

package zewd_pkg;

  localparam int LEN_W   = 28;
  localparam int COUNT_W = 20;
  localparam int HALF_W  = 16;
  localparam int KIND_W  = 3;

  localparam logic [KIND_W-1:0] KIND_HEADER = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SIZE   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_GOOD   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SKIP   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DATA   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_ERROR  = 3'd5;

  localparam logic [1:0] CTRL_GOOD = 2'b11;
  localparam logic [1:0] CTRL_SKIP = 2'b01;

  localparam logic [LEN_W-1:0]   SIZE_OFFSET           = 28'd4;
  localparam logic [LEN_W-1:0]   MAX_EVENT_WORDS_RESET = 28'd100000;
  localparam logic [COUNT_W-1:0] PAIR_MAX              = 20'hFFFFF;

  typedef struct packed {
    logic [31:0] word;
    logic        buffer_start;
  } item_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [LEN_W-1:0]   word_in_event;
    logic [LEN_W-1:0]   event_length;
    logic [COUNT_W-1:0] run_words;
    logic [COUNT_W-1:0] pair_index;
    logic [HALF_W-1:0]  sample_early;
    logic [HALF_W-1:0]  sample_late;
    logic               end_of_event;
  } result_t;

  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

endpackage

FILE: hdl/zewd_in_reg.sv
`timescale 1ns / 1ps

module zewd_in_reg
  import zewd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  item_valid,
  output logic  item_stall,
  input  item_t item,
  input  logic  down_ready,
  output logic  held_valid,
  output item_t held_item
);

  logic take;

  assign take       = !held_valid || down_ready;
  assign item_stall = !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (take) begin
      held_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && item_valid) begin
      held_item <= item;
    end
  end

endmodule

FILE: hdl/zewd_classify.sv
`timescale 1ns / 1ps

module zewd_classify
  import zewd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  item_t            item,
  input  logic [LEN_W-1:0] max_event_words,
  output result_t          result_next
);

  logic [LEN_W-1:0]   words_remaining;
  logic [LEN_W-1:0]   position_in_event;
  logic [LEN_W-1:0]   current_length;
  logic [COUNT_W-1:0] pair_counter;

  logic [LEN_W-1:0]   words_remaining_next;
  logic [LEN_W-1:0]   position_in_event_next;
  logic [LEN_W-1:0]   current_length_next;
  logic [COUNT_W-1:0] pair_counter_next;

  logic [LEN_W-1:0] len;
  logic [1:0]       ctrl;

  assign len  = item.word[LEN_W-1:0];
  assign ctrl = item.word[31:30];

  always_comb begin
    result_next            = '0;
    words_remaining_next   = words_remaining;
    position_in_event_next = position_in_event;
    current_length_next    = current_length;
    pair_counter_next      = pair_counter;

    if (item.buffer_start || words_remaining == '0) begin
      pair_counter_next          = '0;
      position_in_event_next     = '0;
      result_next.event_length   = len;
      result_next.word_in_event  = '0;
      if (len == '0 || len > max_event_words) begin
        result_next.kind         = KIND_ERROR;
        words_remaining_next     = '0;
        current_length_next      = '0;
        result_next.end_of_event = 1'b1;
      end else begin
        result_next.kind         = KIND_HEADER;
        current_length_next      = len;
        words_remaining_next     = len - 28'd1;
        result_next.end_of_event = (len == 28'd1);
      end
    end else begin
      position_in_event_next    = position_in_event + 28'd1;
      words_remaining_next      = words_remaining - 28'd1;
      result_next.word_in_event = position_in_event_next;
      result_next.event_length  = current_length;
      result_next.end_of_event  = (words_remaining_next == '0);
      if (position_in_event_next < SIZE_OFFSET) begin
        result_next.kind = KIND_HEADER;
      end else if (position_in_event_next == SIZE_OFFSET) begin
        result_next.kind = KIND_SIZE;
      end else if (ctrl == CTRL_GOOD) begin
        result_next.kind      = KIND_GOOD;
        result_next.run_words = item.word[COUNT_W-1:0];
        pair_counter_next     = 20'd1;
      end else if (ctrl == CTRL_SKIP) begin
        result_next.kind      = KIND_SKIP;
        result_next.run_words = item.word[COUNT_W-1:0];
      end else begin
        result_next.kind         = KIND_DATA;
        result_next.pair_index   = pair_counter;
        result_next.sample_early = item.word[HALF_W-1:0];
        result_next.sample_late  = item.word[31:HALF_W];
        if (pair_counter != PAIR_MAX) begin
          pair_counter_next = pair_counter + 20'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      words_remaining   <= '0;
      position_in_event <= '0;
      current_length    <= '0;
      pair_counter      <= '0;
    end else if (take) begin
      words_remaining   <= words_remaining_next;
      position_in_event <= position_in_event_next;
      current_length    <= current_length_next;
      pair_counter      <= pair_counter_next;
    end
  end

endmodule

FILE: hdl/zewd_out_reg.sv
`timescale 1ns / 1ps

module zewd_out_reg
  import zewd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  hs_t     up,
  output logic    up_ready,
  input  result_t result_next,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  assign up_ready = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (up_ready) begin
      result_valid <= up.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up.valid) begin
      result <= result_next;
    end
  end

endmodule

FILE: hdl/zle_event_word_deframer_core.sv
`timescale 1ns / 1ps

// Deframer for zero-length-encoded digitizer readout that classifies one 32-bit
// word per clock and gives exactly one result request per word. A word goes
// from the input register through the classifier into the result register,
// and the block sustains one word per cycle while the result side does not
// stall. The event state advances as a word moves from the input register to
// the result register. The length limit is written through the configuration
// channel, which is always ready, and should only change while no request is
// in flight.

module zle_event_word_deframer_core
  import zewd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  item_t            item,
  output logic             result_valid,
  input  logic             result_stall,
  output result_t          result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [LEN_W-1:0] cfg_data
);

  logic             held_valid;
  item_t            held_item;
  logic             up_ready;
  hs_t              up;
  result_t          result_next;
  logic [LEN_W-1:0] max_event_words;

  assign cfg_ready = 1'b1;
  assign up.valid  = held_valid;
  assign up.ready  = up_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_event_words <= MAX_EVENT_WORDS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_event_words <= cfg_data;
    end
  end

  zewd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .down_ready (up_ready),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  zewd_classify u_classify (
    .clk             (clk),
    .rst             (rst),
    .take            (up.valid && up.ready),
    .item            (held_item),
    .max_event_words (max_event_words),
    .result_next     (result_next)
  );

  zewd_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .up           (up),
    .up_ready     (up_ready),
    .result_next  (result_next),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

FILE: hdl/zewd_checker.sv
`timescale 1ns / 1ps

module zewd_checker
  import zewd_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("Result valid right after reset.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("Stalled result request changed.");

  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.kind == KIND_ERROR |->
      result.end_of_event && result.word_in_event == '0)
    else $error("Length error not reported as a closed event.");

  a_non_data_clear: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.kind != KIND_DATA |->
      result.pair_index == '0 && result.sample_early == '0 && result.sample_late == '0)
    else $error("Sample fields set on a word that is not data.");

  a_header_length: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.kind == KIND_HEADER && result.word_in_event == '0 |->
      result.event_length != '0)
    else $error("Accepted header with zero length.");

endmodule

bind zle_event_word_deframer_core zewd_checker u_zewd_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

FILE: verif/zle_event_word_deframer_core_tb.sv
`timescale 1ns / 1ps

module zle_event_word_deframer_core_tb;
  import zewd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic [LEN_W-1:0] LEN_ALL = '1;

  class word_class_board;
    logic [LEN_W-1:0] limit_words;
    logic [LEN_W-1:0] words_left;
    logic [LEN_W-1:0] offset;
    logic [LEN_W-1:0] cur_len;
    logic [COUNT_W-1:0] pair_next;
    result_t queued[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned length_errors;

    function new();
      limit_words = MAX_EVENT_WORDS_RESET;
      words_left = '0;
      offset = '0;
      cur_len = '0;
      pair_next = '0;
      mismatches = 0;
      checked = 0;
      length_errors = 0;
    endfunction

    function void classify_word(item_t it);
      result_t r;
      logic [LEN_W-1:0] len;
      r = '0;
      if (it.buffer_start || words_left == '0) begin
        len = it.word[LEN_W-1:0];
        pair_next = '0;
        offset = '0;
        r.event_length = len;
        if (len == '0 || len > limit_words) begin
          r.kind = KIND_ERROR;
          words_left = '0;
          cur_len = '0;
          r.end_of_event = 1'b1;
          length_errors++;
        end else begin
          r.kind = KIND_HEADER;
          cur_len = len;
          words_left = len - 28'd1;
          r.end_of_event = (words_left == '0);
        end
      end else begin
        offset = offset + 28'd1;
        words_left = words_left - 28'd1;
        r.word_in_event = offset;
        r.event_length = cur_len;
        r.end_of_event = (words_left == '0);
        if (offset < SIZE_OFFSET) begin
          r.kind = KIND_HEADER;
        end else if (offset == SIZE_OFFSET) begin
          r.kind = KIND_SIZE;
        end else if (it.word[31:30] == CTRL_GOOD) begin
          r.kind = KIND_GOOD;
          r.run_words = it.word[COUNT_W-1:0];
          pair_next = 20'd1;
        end else if (it.word[31:30] == CTRL_SKIP) begin
          r.kind = KIND_SKIP;
          r.run_words = it.word[COUNT_W-1:0];
        end else begin
          r.kind = KIND_DATA;
          r.pair_index = pair_next;
          r.sample_early = it.word[15:0];
          r.sample_late = it.word[31:16];
          if (pair_next != PAIR_MAX) begin
            pair_next = pair_next + 20'd1;
          end
        end
      end
      queued.insert(queued.size(), r);
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 40) begin
        $display("deframer mismatch: %s", msg);
      end
    endtask

    task cmp_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) begin
        report($sformatf("result %0d field %s: got 0x%0h, expected 0x%0h",
                         checked, name, got, want));
      end
    endtask

    task check_classification(result_t got);
      result_t want;
      if (queued.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected", checked));
        return;
      end
      want = queued.pop_front();
      cmp_field("kind", 32'(got.kind), 32'(want.kind));
      cmp_field("word_in_event", 32'(got.word_in_event), 32'(want.word_in_event));
      cmp_field("event_length", 32'(got.event_length), 32'(want.event_length));
      cmp_field("run_words", 32'(got.run_words), 32'(want.run_words));
      cmp_field("pair_index", 32'(got.pair_index), 32'(want.pair_index));
      cmp_field("sample_early", 32'(got.sample_early), 32'(want.sample_early));
      cmp_field("sample_late", 32'(got.sample_late), 32'(want.sample_late));
      cmp_field("end_of_event", 32'(got.end_of_event), 32'(want.end_of_event));
      checked++;
    endtask
  endclass

  logic clk;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [LEN_W-1:0] cfg_data = '0;

  word_class_board board;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  int unsigned words_sent = 0;
  int unsigned limit_settings = 0;
  bit no_gaps = 1'b0;
  bit rx_quiet = 1'b0;
  bit hold_req = 1'b0;

  zle_event_word_deframer_core dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("zle_event_word_deframer_core_tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && !item_stall) begin
        board.classify_word(item);
      end
      if (result_valid && !result_stall) begin
        board.check_classification(result);
      end
    end
  end

  initial begin : rx_pattern
    int unsigned seg_left;
    int unsigned stall_pct;
    int unsigned hold_left;
    bit hold_seen;
    seg_left = 0;
    stall_pct = 0;
    hold_left = 0;
    hold_seen = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = 400;
      end
      if (hold_left != 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else if (rx_quiet) begin
        result_stall <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(4, 90);
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 25;
            2: stall_pct = 50;
            default: stall_pct = 85;
          endcase
        end
        seg_left--;
        result_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  task automatic send_word(input logic [31:0] w, input logic bs);
    int unsigned gap;
    if (burst_left == 0 && !no_gaps) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    if (burst_left != 0) begin
      burst_left--;
    end
    item <= {w, bs};
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    words_sent++;
  endtask

  task automatic drain_results();
    item_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (board.queued.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LEN_W-1:0] v);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.limit_words = v;
    limit_settings++;
  endtask

  task automatic send_event(input logic [LEN_W-1:0] len, input int unsigned cut,
                            input logic bs);
    logic [31:0] w;
    int unsigned pick;
    w = $urandom();
    w[LEN_W-1:0] = len;
    send_word(w, bs);
    for (int unsigned i = 1; i < 32'(len) && i < cut; i++) begin
      w = $urandom();
      if (i > 4) begin
        pick = $urandom_range(0, 99);
        if (pick < 18) begin
          w[31:30] = CTRL_GOOD;
        end else if (pick < 28) begin
          w[31:30] = CTRL_SKIP;
        end else begin
          w[30] = 1'b0;
        end
      end
      send_word(w, 1'b0);
    end
  endtask

  task automatic random_phase(input logic [LEN_W-1:0] lim, input int unsigned n_words);
    int unsigned first;
    int unsigned pick;
    int unsigned len_cap;
    logic [LEN_W-1:0] len;
    logic open_event;
    drain_results();
    write_limit(lim);
    first = words_sent;
    open_event = 1'b1;
    while (words_sent - first < n_words) begin
      pick = $urandom_range(0, 99);
      if (lim < 40) begin
        len_cap = 32'(lim);
      end else if ($urandom_range(0, 9) == 0) begin
        len_cap = (lim < 300) ? 32'(lim) : 300;
      end else begin
        len_cap = 40;
      end
      len = LEN_W'($urandom_range(1, len_cap));
      if (pick < 72) begin
        send_event(len, 32'(len), open_event || ($urandom_range(0, 7) == 0));
        open_event = 1'b0;
      end else if (pick < 82) begin
        if (lim == LEN_ALL || $urandom_range(0, 2) == 0) begin
          len = '0;
        end else begin
          len = LEN_W'($urandom_range(32'(lim) + 1, 32'(LEN_ALL)));
        end
        send_event(len, 1, open_event || ($urandom_range(0, 7) == 0));
        open_event = 1'b0;
      end else if (pick < 92) begin
        send_event(len, $urandom_range(1, 32'(len)),
                   open_event || ($urandom_range(0, 7) == 0));
        open_event = 1'b1;
      end else begin
        repeat ($urandom_range(1, 6)) send_word($urandom(), $urandom_range(0, 7) == 0);
        open_event = 1'b1;
      end
    end
  endtask

  initial begin
    int unsigned first;
    board = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_word(32'h0000_0000, 1'b0);
    send_word(32'hF001_86A1, 1'b0);
    send_word(32'h3001_86A0, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'h4000_0000, 1'b0);
    send_word(32'h8000_0003, 1'b1);
    send_word(32'hC000_0001, 1'b0);
    send_word(32'h4000_0002, 1'b0);
    send_word(32'h0000_0001, 1'b1);
    send_word(32'h0000_000B, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'hC00F_FFFF, 1'b0);
    send_word(32'h7FFF_FFFF, 1'b0);
    send_word(32'h0123_4567, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'h8000_0000, 1'b0);
    send_word(32'h3FFF_FFFF, 1'b0);
    send_word(32'h4000_0000, 1'b0);
    send_word(32'hBFFF_FFFF, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    drain_results();
    write_limit(28'd1);
    send_word(32'h0000_0001, 1'b0);
    send_word(32'h0000_0002, 1'b0);

    random_phase(28'd1, 120);
    random_phase(28'd4, 150);
    random_phase(28'd5, 150);
    random_phase(28'd12, 150);
    random_phase(28'd64, 150);
    random_phase(LEN_W'($urandom_range(6, 500)), 150);
    random_phase(MAX_EVENT_WORDS_RESET, 150);
    random_phase(LEN_ALL, 150);
    random_phase(LEN_W'($urandom_range(1, 32'(LEN_ALL))), 150);

    // The receiver holds off while the sender keeps offering whole events.
    drain_results();
    write_limit(28'd200);
    hold_req = !hold_req;
    first = words_sent;
    while (words_sent - first < 150) begin
      send_event(LEN_W'($urandom_range(1, 30)), 30, 1'b1);
    end

    // One event sent back to back with the receiver always ready.
    drain_results();
    rx_quiet = 1'b1;
    no_gaps = 1'b1;
    send_event(28'd40, 40, 1'b1);
    drain_results();
    rx_quiet = 1'b0;
    no_gaps = 1'b0;
    random_phase(MAX_EVENT_WORDS_RESET, 60);

    drain_results();
    repeat (10) @(posedge clk);
    if (board.queued.size() != 0) begin
      board.report("expected results left over at the end");
    end
    $display("Run sent %0d words, checked %0d results under %0d length limits.",
             words_sent, board.checked, limit_settings);
    $display("It saw %0d length errors, one long stall and one gap-free event.",
             board.length_errors);
    if (board.mismatches == 0) begin
      $display("zle_event_word_deframer_core_tb: PASS");
    end else begin
      $display("zle_event_word_deframer_core_tb: FAIL");
    end
    $finish;
  end

endmodule
